/* sv/spq_pkg.sv */
package spq_pkg;

  // queue geometry
  localparam int DEPTH      = 64;
  localparam int TAG_WIDTH  = 16;
  localparam int PRIO_WIDTH = 16;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // port field widths
  localparam int OP_W     = 2;
  localparam int TAG_W    = 16;
  localparam int PRIO_W   = 16;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  // request opcodes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SERVE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // one queue slot
  typedef struct packed {
    logic                  valid;
    logic [TAG_WIDTH-1:0]  tag;
    logic [PRIO_WIDTH-1:0] prio;
  } entry_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic ins;
    logic srv;
    logic clr;
  } cell_cmd_t;

endpackage

/* sv/spq_cell.sv */
module spq_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  spq_pkg::cell_cmd_t             cmd,
  input  logic [spq_pkg::TAG_WIDTH-1:0]  new_tag,
  input  logic [spq_pkg::PRIO_WIDTH-1:0] new_prio,
  input  spq_pkg::entry_t                prev_ent,
  input  logic                           prev_keep,
  input  spq_pkg::entry_t                next_ent,
  output spq_pkg::entry_t                ent,
  output logic                           keep
);

  spq_pkg::entry_t ent_next;

  // entry stays ahead of a new one of equal or lower priority
  assign keep = ent.valid && (ent.prio >= new_prio);

  // clear: drop the valid bit; insert: keep, take the new entry, or take the neighbor's; serve: shift forward
  always_comb begin
    ent_next = ent;
    priority if (cmd.clr) begin
      ent_next.valid = 1'b0;
    end else if (cmd.ins) begin
      if (!keep) begin
        if (prev_keep) begin
          ent_next.valid = 1'b1;
          ent_next.tag   = new_tag;
          ent_next.prio  = new_prio;
        end else begin
          ent_next = prev_ent;
        end
      end
    end else if (cmd.srv) begin
      ent_next = next_ent;
    end
  end

  // only the valid bit is cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent <= ent_next;
    end
  end

endmodule

/* sv/stable_priority_queue.sv */
// channel  | handshake              | payload
// ---------+------------------------+-------------------------------------
// in       | in_valid / in_stall    | opcode, tag, priority_req
// out      | out_valid / out_stall  | served_tag, status, occupancy
//
// one request per cycle while in_stall is low; each request gives its result
// in the output register on the next cycle; the cells update at the accepting
// edge, one priority compare per cell, entries moving one cell per request
// reset clears the cell valid bits and the count at once, no sweep needed
// in_stall is high only while a result waits and out_stall is high
module stable_priority_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [spq_pkg::OP_W-1:0]       opcode,
  input  logic [spq_pkg::TAG_W-1:0]      tag,
  input  logic [spq_pkg::PRIO_W-1:0]     priority_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [spq_pkg::TAG_W-1:0]      served_tag,
  output logic [spq_pkg::STATUS_W-1:0]   status,
  output logic [spq_pkg::OCC_W-1:0]      occupancy
);

  localparam int D = spq_pkg::DEPTH;

  logic                             accept;
  logic                             full;
  logic                             empty;
  logic [spq_pkg::CNT_W-1:0]        count;
  logic [spq_pkg::CNT_W-1:0]        count_next;
  logic [spq_pkg::STATUS_W-1:0]     status_next;
  logic [spq_pkg::TAG_W-1:0]        served_tag_next;
  logic [spq_pkg::TAG_WIDTH-1:0]    new_tag;
  logic [spq_pkg::PRIO_WIDTH-1:0]   new_prio;
  spq_pkg::cell_cmd_t               cmd;
  spq_pkg::entry_t                  ent   [D];
  logic                             keep  [D];
  logic [D-1:0]                     valid_vec;

  // request handshake
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign full  = (count == spq_pkg::CNT_W'(D));
  assign empty = (count == '0);

  assign new_tag  = spq_pkg::TAG_WIDTH'(tag);
  assign new_prio = spq_pkg::PRIO_WIDTH'(priority_req);

  // decode the request into the cell command
  always_comb begin
    cmd             = '0;
    count_next      = count;
    status_next     = spq_pkg::ST_OK;
    served_tag_next = '0;
    if (accept) begin
      unique case (opcode)
        spq_pkg::OP_INSERT: begin
          if (full) begin
            status_next = spq_pkg::ST_FULL;
          end else begin
            cmd.ins    = 1'b1;
            count_next = count + 1'b1;
          end
        end
        spq_pkg::OP_SERVE: begin
          if (empty) begin
            status_next = spq_pkg::ST_EMPTY;
          end else begin
            cmd.srv         = 1'b1;
            count_next      = count - 1'b1;
            served_tag_next = spq_pkg::TAG_W'(ent[0].tag);
          end
        end
        spq_pkg::OP_CLEAR: begin
          cmd.clr    = 1'b1;
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // row of cells, best entry in cell zero
  for (genvar i = 0; i < D; i++) begin : g_cell
    spq_pkg::entry_t prev_ent;
    spq_pkg::entry_t next_ent;
    logic            prev_keep;

    if (i == 0) begin : g_head
      assign prev_ent  = '0;
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_ent  = ent[i-1];
      assign prev_keep = keep[i-1];
    end

    if (i == D - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_mid
      assign next_ent = ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .new_tag   (new_tag),
      .new_prio  (new_prio),
      .prev_ent  (prev_ent),
      .prev_keep (prev_keep),
      .next_ent  (next_ent),
      .ent       (ent[i]),
      .keep      (keep[i])
    );

    assign valid_vec[i] = ent[i].valid;
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      served_tag <= served_tag_next;
      status     <= status_next;
      occupancy  <= spq_pkg::OCC_W'(count_next);
    end
  end

  // count never passes the number of cells
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_W'(D))
    else $error("entry count above depth");

  // valid cells match the count
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("valid cells disagree with count");

  // a serve removes exactly one entry
  a_serve_count: assert property (@(posedge clk) disable iff (rst)
    cmd.srv |=> count == spq_pkg::CNT_W'($past(count) - 1'b1))
    else $error("serve did not remove one entry");

  // every accepted request shows a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request gave no result");

  // empty status only comes with an empty queue
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == spq_pkg::ST_EMPTY |-> occupancy == '0)
    else $error("empty status with entries held");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;

  // opcode left unused by the block
  localparam logic [spq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // random block kinds
  localparam int BLK_FILL  = 0;
  localparam int BLK_DRAIN = 1;
  localparam int BLK_MIXED = 2;

  localparam int RANDOM_ITEMS = 800;

  typedef struct {
    logic [spq_pkg::TAG_W-1:0]    served_tag;
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::OCC_W-1:0]    occupancy;
  } queue_result_t;

  typedef struct {
    logic [spq_pkg::OP_W-1:0]   op;
    logic [spq_pkg::TAG_W-1:0]  tg;
    logic [spq_pkg::PRIO_W-1:0] pr;
    bit                         literal;
    queue_result_t              res;
  } directed_row_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic [spq_pkg::OP_W-1:0]     opcode;
  logic [spq_pkg::TAG_W-1:0]    tag;
  logic [spq_pkg::PRIO_W-1:0]   priority_req;
  logic                         out_valid;
  logic                         out_stall;
  logic [spq_pkg::TAG_W-1:0]    served_tag;
  logic [spq_pkg::STATUS_W-1:0] status;
  logic [spq_pkg::OCC_W-1:0]    occupancy;

  // sorted copy of the queue, best entry at index zero
  logic [spq_pkg::TAG_W-1:0]  sorted_tag [spq_pkg::DEPTH];
  logic [spq_pkg::PRIO_W-1:0] sorted_prio [spq_pkg::DEPTH];
  int                         held_count;

  queue_result_t pending_results[$];
  directed_row_t directed_rows[$];
  queue_result_t want;
  int            errors;
  int            tx_idle_pct;
  int            rx_cycle;

  stable_priority_queue dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .tag          (tag),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .served_tag   (served_tag),
    .status       (status),
    .occupancy    (occupancy)
  );

  always #6 clk = ~clk;

  // apply one request to the sorted copy and return its result
  function automatic queue_result_t apply_queue_op(logic [spq_pkg::OP_W-1:0] op,
                                                   logic [spq_pkg::TAG_W-1:0] tg,
                                                   logic [spq_pkg::PRIO_W-1:0] pr);
    queue_result_t r;
    int pos;
    r.served_tag = '0;
    r.status = spq_pkg::ST_OK;
    case (op)
      spq_pkg::OP_INSERT: begin
        if (held_count >= spq_pkg::DEPTH) begin
          r.status = spq_pkg::ST_FULL;
        end else begin
          // goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < held_count && sorted_prio[pos] >= pr) pos++;
          for (int i = held_count; i > pos; i--) begin
            sorted_tag[i] = sorted_tag[i-1];
            sorted_prio[i] = sorted_prio[i-1];
          end
          sorted_tag[pos] = tg;
          sorted_prio[pos] = pr;
          held_count++;
        end
      end
      spq_pkg::OP_SERVE: begin
        if (held_count == 0) begin
          r.status = spq_pkg::ST_EMPTY;
        end else begin
          r.served_tag = sorted_tag[0];
          for (int i = 0; i + 1 < held_count; i++) begin
            sorted_tag[i] = sorted_tag[i+1];
            sorted_prio[i] = sorted_prio[i+1];
          end
          held_count--;
        end
      end
      spq_pkg::OP_CLEAR: held_count = 0;
      default: ;
    endcase
    r.occupancy = held_count[spq_pkg::OCC_W-1:0];
    return r;
  endfunction

  function automatic void add_row(logic [spq_pkg::OP_W-1:0] op,
                                  logic [spq_pkg::TAG_W-1:0] tg,
                                  logic [spq_pkg::PRIO_W-1:0] pr, bit literal,
                                  logic [spq_pkg::TAG_W-1:0] r_tag,
                                  logic [spq_pkg::STATUS_W-1:0] r_status,
                                  logic [spq_pkg::OCC_W-1:0] r_occ);
    directed_row_t row;
    row.op = op;
    row.tg = tg;
    row.pr = pr;
    row.literal = literal;
    row.res.served_tag = r_tag;
    row.res.status = r_status;
    row.res.occupancy = r_occ;
    directed_rows.push_back(row);
  endfunction

  // offer one request, hold it until accepted, then record its result
  task automatic offer_request(logic [spq_pkg::OP_W-1:0] op,
                               logic [spq_pkg::TAG_W-1:0] tg,
                               logic [spq_pkg::PRIO_W-1:0] pr, bit literal,
                               queue_result_t lit);
    queue_result_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    tag <= tg;
    priority_req <= pr;
    do @(posedge clk); while (in_stall);
    predicted = apply_queue_op(op, tg, pr);
    pending_results.push_back(literal ? lit : predicted);
    @(negedge clk);
  endtask

  // random priority with many ties and frequent extremes
  function automatic logic [spq_pkg::PRIO_W-1:0] pick_prio();
    case ($urandom_range(0, 3))
      0: return spq_pkg::PRIO_W'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return spq_pkg::PRIO_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [spq_pkg::OP_W-1:0] pick_op(int kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      BLK_FILL:
        return (r < 88) ? spq_pkg::OP_INSERT : (r < 97) ? spq_pkg::OP_SERVE : OP_UNUSED;
      BLK_DRAIN:
        return (r < 85) ? spq_pkg::OP_SERVE : (r < 93) ? spq_pkg::OP_INSERT :
               (r < 97) ? OP_UNUSED : spq_pkg::OP_CLEAR;
      default:
        return (r < 45) ? spq_pkg::OP_INSERT : (r < 90) ? spq_pkg::OP_SERVE :
               (r < 95) ? OP_UNUSED : spq_pkg::OP_CLEAR;
    endcase
  endfunction

  // stimulus
  initial begin
    int sent;
    int kind;
    int blk_len;
    queue_result_t none;
    logic [spq_pkg::OP_W-1:0] op;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = spq_pkg::OP_INSERT;
    tag = '0;
    priority_req = '0;
    errors = 0;
    held_count = 0;
    tx_idle_pct = 33;
    none = '{default: '0};

    // directed rows: extremes, ties, every opcode and the special cases
    add_row(spq_pkg::OP_SERVE, 16'h0000, 16'h0000, 1, 16'h0000, spq_pkg::ST_EMPTY, 7'd0);
    add_row(spq_pkg::OP_CLEAR, 16'h0000, 16'h0000, 1, 16'h0000, spq_pkg::ST_OK, 7'd0);
    add_row(spq_pkg::OP_INSERT, 16'hFFFF, 16'hFFFF, 1, 16'h0000, spq_pkg::ST_OK, 7'd1);
    add_row(spq_pkg::OP_INSERT, 16'h0000, 16'h0000, 1, 16'h0000, spq_pkg::ST_OK, 7'd2);
    add_row(spq_pkg::OP_INSERT, 16'h1234, 16'hFFFF, 0, 16'h0000, spq_pkg::ST_OK, 7'd0);
    add_row(spq_pkg::OP_INSERT, 16'hAAAA, 16'h8000, 0, 16'h0000, spq_pkg::ST_OK, 7'd0);
    add_row(spq_pkg::OP_INSERT, 16'h5555, 16'h0000, 0, 16'h0000, spq_pkg::ST_OK, 7'd0);
    add_row(OP_UNUSED, 16'hBEEF, 16'hBEEF, 1, 16'h0000, spq_pkg::ST_OK, 7'd5);
    add_row(spq_pkg::OP_SERVE, 16'hFFFF, 16'hFFFF, 0, 16'h0000, spq_pkg::ST_OK, 7'd0);
    add_row(spq_pkg::OP_SERVE, 16'h0000, 16'h0000, 0, 16'h0000, spq_pkg::ST_OK, 7'd0);
    add_row(spq_pkg::OP_SERVE, 16'h0000, 16'h0000, 0, 16'h0000, spq_pkg::ST_OK, 7'd0);
    add_row(spq_pkg::OP_SERVE, 16'h0000, 16'h0000, 0, 16'h0000, spq_pkg::ST_OK, 7'd0);
    add_row(spq_pkg::OP_SERVE, 16'h0000, 16'h0000, 0, 16'h0000, spq_pkg::ST_OK, 7'd0);
    add_row(spq_pkg::OP_SERVE, 16'h0000, 16'h0000, 1, 16'h0000, spq_pkg::ST_EMPTY, 7'd0);
    add_row(spq_pkg::OP_INSERT, 16'h0001, 16'h0001, 0, 16'h0000, spq_pkg::ST_OK, 7'd0);
    add_row(spq_pkg::OP_INSERT, 16'h0002, 16'h0002, 0, 16'h0000, spq_pkg::ST_OK, 7'd0);
    add_row(spq_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 1, 16'h0000, spq_pkg::ST_OK, 7'd0);
    add_row(spq_pkg::OP_SERVE, 16'h0000, 16'h0000, 1, 16'h0000, spq_pkg::ST_EMPTY, 7'd0);
    add_row(spq_pkg::OP_INSERT, 16'h0007, 16'h0007, 1, 16'h0000, spq_pkg::ST_OK, 7'd1);
    add_row(spq_pkg::OP_INSERT, 16'h0008, 16'h0007, 0, 16'h0000, spq_pkg::ST_OK, 7'd0);
    add_row(spq_pkg::OP_SERVE, 16'h0000, 16'h0000, 0, 16'h0000, spq_pkg::ST_OK, 7'd0);
    add_row(spq_pkg::OP_SERVE, 16'h0000, 16'h0000, 0, 16'h0000, spq_pkg::ST_OK, 7'd0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      offer_request(directed_rows[i].op, directed_rows[i].tg, directed_rows[i].pr,
                    directed_rows[i].literal, directed_rows[i].res);

    // random blocks: fill to the top, drain to empty, mixed traffic
    sent = 0;
    kind = BLK_FILL;
    while (sent < RANDOM_ITEMS) begin
      blk_len = (kind == BLK_FILL) ? $urandom_range(80, 120) : $urandom_range(30, 90);
      for (int k = 0; k < blk_len && sent < RANDOM_ITEMS; k++) begin
        tx_idle_pct = (sent >= 300 && sent < 420) ? 0 : 33;
        op = pick_op(kind);
        offer_request(op, spq_pkg::TAG_W'($urandom_range(0, 65535)), pick_prio(), 0,
                      none);
        sent++;
      end
      kind = (kind + 1 + $urandom_range(0, 1)) % 3;
    end
    in_valid <= 1'b0;

    // drain outstanding results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // receiver stall: random, one long hold-off, one stretch with none
  initial begin
    out_stall = 1'b0;
    rx_cycle = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle >= 400 && rx_cycle < 700)
        out_stall <= 1'b1;
      else if (rx_cycle >= 1200 && rx_cycle < 1600)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(0, 99) < 33);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request waiting: tag %h status %0d occupancy %0d",
                 $time, served_tag, status, occupancy);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (served_tag !== want.served_tag) begin
          $display("%0t: served_tag expected %h actual %h", $time, want.served_tag,
                   served_tag);
          errors++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
        if (occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                   occupancy);
          errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_queue.sv
tb/sv/tb.sv
